@@ design/wspa_pkg.sv @@
// ----------------------------------------------------------------------------
// wspa_pkg
// Shared constants, register codes and types of the wheel speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package wspa_pkg;

	localparam int FULL_SCALE     = 16384;
	localparam int GAIN_FRAC_BITS = 8;

	localparam int CNT_W   = 32;
	localparam int SPD_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int SLIP_W  = 15;
	localparam int ERR_W   = SPD_W + 1;
	localparam int DERR_W  = SPD_W + 2;
	localparam int ACC_W   = GAIN_W + DERR_W + 2;
	localparam int EMF_W   = GAIN_W + SPD_W + 2;
	localparam int CIDX_W  = 3;

	typedef enum logic [CIDX_W-1:0] {
		REG_GAIN_P_LOW  = 3'd0,
		REG_GAIN_I_LOW  = 3'd1,
		REG_GAIN_P_HIGH = 3'd2,
		REG_GAIN_I_HIGH = 3'd3,
		REG_LOW_THRESH  = 3'd4,
		REG_EMF_GAIN    = 3'd5,
		REG_SLIP_LIMIT  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        [GAIN_W-1:0] gain_p_low;
		logic        [GAIN_W-1:0] gain_i_low;
		logic        [GAIN_W-1:0] gain_p_high;
		logic        [GAIN_W-1:0] gain_i_high;
		logic signed [SPD_W-1:0]  low_speed_threshold;
		logic        [GAIN_W-1:0] emf_gain;
		logic        [SLIP_W-1:0] slip_limit;
	} cfg_t;

	localparam logic [GAIN_W-1:0] RST_GAIN_P_LOW  = 16'd20;
	localparam logic [GAIN_W-1:0] RST_GAIN_I_LOW  = 16'd1;
	localparam logic [GAIN_W-1:0] RST_GAIN_P_HIGH = 16'd2;
	localparam logic [GAIN_W-1:0] RST_GAIN_I_HIGH = 16'd0;
	localparam logic [SPD_W-1:0]  RST_LOW_THRESH  = 16'd10;
	localparam logic [GAIN_W-1:0] RST_EMF_GAIN    = 16'd256;
	localparam logic [SLIP_W-1:0] RST_SLIP_LIMIT  = 15'd8192;

	// saturate a 32-bit signed value to 16 signed bits
	function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [CNT_W-1:0] v);
		logic signed [CNT_W-1:0] hi;
		logic signed [CNT_W-1:0] lo;
		hi = CNT_W'(32767);
		lo = -CNT_W'(32768);
		if (v > hi)
			return SPD_W'(hi);
		else if (v < lo)
			return SPD_W'(lo);
		else
			return SPD_W'(v);
	endfunction

endpackage

`default_nettype wire

@@ design/wspa_cfg.sv @@
// ----------------------------------------------------------------------------
// wspa_cfg
// Configuration register bank: gains, speed threshold, back-EMF gain, slip.
// ----------------------------------------------------------------------------
`default_nettype none

module wspa_cfg
	import wspa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [CIDX_W-1:0] wr_index,
	input  wire logic [GAIN_W-1:0] wr_data,
	output      cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p_low          <= RST_GAIN_P_LOW;
			cfg_q.gain_i_low          <= RST_GAIN_I_LOW;
			cfg_q.gain_p_high         <= RST_GAIN_P_HIGH;
			cfg_q.gain_i_high         <= RST_GAIN_I_HIGH;
			cfg_q.low_speed_threshold <= RST_LOW_THRESH;
			cfg_q.emf_gain            <= RST_EMF_GAIN;
			cfg_q.slip_limit          <= RST_SLIP_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAIN_P_LOW:  cfg_q.gain_p_low          <= wr_data;
				REG_GAIN_I_LOW:  cfg_q.gain_i_low          <= wr_data;
				REG_GAIN_P_HIGH: cfg_q.gain_p_high         <= wr_data;
				REG_GAIN_I_HIGH: cfg_q.gain_i_high         <= wr_data;
				REG_LOW_THRESH:  cfg_q.low_speed_threshold <= wr_data;
				REG_EMF_GAIN:    cfg_q.emf_gain            <= wr_data;
				REG_SLIP_LIMIT:  cfg_q.slip_limit          <= wr_data[SLIP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ design/wspa_wheel.sv @@
// ----------------------------------------------------------------------------
// wspa_wheel
// One wheel: speed from encoder counts, incremental PI step with scheduled
// gains, full-scale and anti-slip clamps, and the wheel's state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wspa_wheel
	import wspa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cfg_t                    cfg,
	input  wire logic                    commit,
	input  wire logic                    kind,
	input  wire logic signed [CNT_W-1:0] value,
	output      logic signed [SPD_W-1:0] drive_nxt,
	output      logic signed [SPD_W-1:0] speed_nxt,
	output      logic                    changed
);

	logic signed [CNT_W-1:0]  prev_count_q;
	logic signed [SPD_W-1:0]  speed_q;
	logic signed [SPD_W-1:0]  target_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [SPD_W-1:0]  drive_q;

	logic signed [CNT_W-1:0]  diff;
	logic signed [SPD_W-1:0]  w;
	logic signed [SPD_W-1:0]  tgt;
	logic signed [ERR_W-1:0]  err;
	logic signed [DERR_W-1:0] derr;
	logic                     low;
	logic        [GAIN_W-1:0] kp;
	logic        [GAIN_W-1:0] ki;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  u0;
	logic signed [ACC_W-1:0]  fs_acc;
	logic signed [SPD_W-1:0]  u1;
	logic signed [EMF_W-1:0]  emf;
	logic signed [EMF_W-1:0]  umax;
	logic signed [EMF_W-1:0]  umin;
	logic signed [EMF_W-1:0]  u2;
	logic signed [EMF_W-1:0]  fs_emf;
	logic signed [SPD_W-1:0]  u3;

	always_comb begin
		diff = value - prev_count_q;
		w    = kind ? speed_q : sat_spd(diff);
		tgt  = kind ? sat_spd(value) : target_q;
		err  = ERR_W'(tgt) - ERR_W'(w);
		derr = DERR_W'(err) - DERR_W'(prev_err_q);

		low = (w < cfg.low_speed_threshold);
		kp  = low ? cfg.gain_p_low : cfg.gain_p_high;
		ki  = low ? cfg.gain_i_low : cfg.gain_i_high;

		acc = ACC_W'($signed({1'b0, kp}) * derr) + ACC_W'($signed({1'b0, ki}) * err);
		u0  = (acc >>> GAIN_FRAC_BITS) + ACC_W'(drive_q);

		fs_acc = ACC_W'(FULL_SCALE);
		if (u0 > fs_acc)
			u1 = SPD_W'(fs_acc);
		else if (u0 < -fs_acc)
			u1 = SPD_W'(-fs_acc);
		else
			u1 = SPD_W'(u0);

		// anti-slip window around back-EMF level
		emf  = EMF_W'($signed({1'b0, cfg.emf_gain}) * w) >>> GAIN_FRAC_BITS;
		umax = emf + EMF_W'({1'b0, cfg.slip_limit});
		umin = emf - EMF_W'({1'b0, cfg.slip_limit});
		u2   = EMF_W'(u1);
		if (u2 > umax)
			u2 = umax;
		if (u2 < umin)
			u2 = umin;

		fs_emf = EMF_W'(FULL_SCALE);
		if (u2 > fs_emf)
			u3 = SPD_W'(fs_emf);
		else if (u2 < -fs_emf)
			u3 = SPD_W'(-fs_emf);
		else
			u3 = SPD_W'(u2);
	end

	assign drive_nxt = u3;
	assign speed_nxt = w;
	assign changed   = (u3 != drive_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			speed_q      <= '0;
			target_q     <= '0;
			prev_err_q   <= '0;
			drive_q      <= '0;
		end else if (commit) begin
			if (kind) begin
				target_q <= tgt;
			end else begin
				prev_count_q <= value;
				speed_q      <= w;
			end
			prev_err_q <= err;
			drive_q    <= u3;
		end
	end

endmodule

`default_nettype wire

@@ design/wheel_speed_pi_antislip_core.sv @@
// ----------------------------------------------------------------------------
// wheel_speed_pi_antislip_core
// Two-wheel incremental PI speed controller with anti-slip drive clamp.
// ----------------------------------------------------------------------------
// Channels: an input item (kind, left_value, right_value) is taken on
// in_valid & in_ready; kind 0 carries absolute encoder counts, kind 1 sets
// target speeds. A result item (drive_left/right, speed_left/right) is given
// on out_valid & out_ready. Configuration writes use cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, unknown indexes are
// dropped. Write configuration only while the block is idle.
// An accepted item is held in the input register until it is committed; its
// result, if any, is then written to the result register and shown on
// out_valid. Target items always give a result; encoder items give one
// only when either drive changes.
// Throughput: one item per cycle; both wheels update state (speed, error,
// drive) combinationally between the input and result registers. When the
// receiver stalls with a result held, the input register still takes items
// that give no result; it waits only on an item that must send a result.
// Reset clears all wheel state and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_speed_pi_antislip_core
	import wspa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	input  wire logic                    cfg_valid,
	output      logic                    cfg_ready,
	input  wire logic [CIDX_W-1:0]       cfg_index,
	input  wire logic [GAIN_W-1:0]       cfg_data,

	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire logic                    kind,
	input  wire logic signed [CNT_W-1:0] left_value,
	input  wire logic signed [CNT_W-1:0] right_value,

	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      logic signed [SPD_W-1:0] drive_left,
	output      logic signed [SPD_W-1:0] drive_right,
	output      logic signed [SPD_W-1:0] speed_left,
	output      logic signed [SPD_W-1:0] speed_right
);

	cfg_t                    cfg;

	logic                    valid_s1;
	logic                    kind_s1;
	logic signed [CNT_W-1:0] left_s1;
	logic signed [CNT_W-1:0] right_s1;

	logic signed [SPD_W-1:0] drv_l;
	logic signed [SPD_W-1:0] drv_r;
	logic signed [SPD_W-1:0] spd_l;
	logic signed [SPD_W-1:0] spd_r;
	logic                    chg_l;
	logic                    chg_r;
	logic                    send;
	logic                    fire;

	logic                    out_valid_q;
	logic signed [SPD_W-1:0] drive_left_q;
	logic signed [SPD_W-1:0] drive_right_q;
	logic signed [SPD_W-1:0] speed_left_q;
	logic signed [SPD_W-1:0] speed_right_q;

	assign cfg_ready = 1'b1;

	wspa_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	wspa_wheel u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.commit    (fire),
		.kind      (kind_s1),
		.value     (left_s1),
		.drive_nxt (drv_l),
		.speed_nxt (spd_l),
		.changed   (chg_l)
	);

	wspa_wheel u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.commit    (fire),
		.kind      (kind_s1),
		.value     (right_s1),
		.drive_nxt (drv_r),
		.speed_nxt (spd_r),
		.changed   (chg_r)
	);

	assign send     = kind_s1 | chg_l | chg_r;
	assign fire     = valid_s1 & (~send | ~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			left_s1  <= left_value;
			right_s1 <= right_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && send) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && send) begin
			drive_left_q  <= drv_l;
			drive_right_q <= drv_r;
			speed_left_q  <= spd_l;
			speed_right_q <= spd_r;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_left  = drive_left_q;
	assign drive_right = drive_right_q;
	assign speed_left  = speed_left_q;
	assign speed_right = speed_right_q;

	a_target_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && kind_s1 |=> out_valid)
		else $error("target item gave no result");

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |-> send && out_valid_q && !out_ready)
		else $error("input register stalled without cause");

	a_silent_step_keeps_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !send |=> out_valid == $past(out_valid_q && !out_ready))
		else $error("result appeared or vanished on a silent step");

	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_left <= SPD_W'(FULL_SCALE)) && (drive_left >= -SPD_W'(FULL_SCALE))
			&& (drive_right <= SPD_W'(FULL_SCALE)) && (drive_right >= -SPD_W'(FULL_SCALE)))
		else $error("drive outside full scale");

endmodule

`default_nettype wire
